// ===== hdl/jfbs_pkg.sv =====
// jfbs_pkg: constants and shared types for the jpeg frame boundary scanner
// used by jfbs_scan and jpeg_frame_boundary_scanner_core; no dependencies
package jfbs_pkg;

   // width of the internal offset counters (wraps modulo 2**OffsetBits)
   localparam int OffsetBits = 32;
   // width of the reported start and length fields
   localparam int ResultBits = 32;

   localparam logic [7:0] MarkerPrefix = 8'hFF;
   localparam logic [7:0] SoiCode      = 8'hD8;
   localparam logic [7:0] EoiCode      = 8'hD9;
   localparam logic [7:0] AppMask      = 8'hF0;
   localparam logic [7:0] AppCode      = 8'hE0;

   typedef logic [OffsetBits-1:0] offset_type;

   typedef struct packed {
      logic                  found;
      logic [ResultBits-1:0] start;
      logic [ResultBits-1:0] length;
   } scan_result_type;

endpackage

// ===== hdl/jfbs_scan.sv =====
// jfbs_scan: marker scan state and its one-byte next-state logic
// depends on jfbs_pkg; advances once per step_en, clears after the last byte
module jfbs_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output jfbs_pkg::scan_result_type result
);

   typedef enum logic [2:0] {
      PH_SOI,
      PH_APPMARK,
      PH_APPTYPE,
      PH_LENHI,
      PH_LENLO,
      PH_SKIP,
      PH_EOI,
      PH_DONE
   } phase_type;

   phase_type            phase_ff, phase_in;
   jfbs_pkg::offset_type pos_ff, pos_in;
   jfbs_pkg::offset_type start_ff, start_in;
   jfbs_pkg::offset_type length_ff, length_in;
   logic                 prev_ff_ff, prev_ff_in;
   logic [7:0]           len_hi_ff, len_hi_in;
   logic [15:0]          skip_ff, skip_in;
   logic                 found_ff, found_in;

   logic        is_ff;
   logic        is_eoi;
   logic [15:0] seg_len;
   logic [15:0] seg_skip;
   jfbs_pkg::offset_type eoi_length;

   assign is_ff      = (data_byte == jfbs_pkg::MarkerPrefix);
   assign is_eoi     = (data_byte == jfbs_pkg::EoiCode);
   assign seg_len    = {len_hi_ff, data_byte};
   // lengths below two count as two
   assign seg_skip   = (seg_len < 16'd2) ? 16'd0 : seg_len - 16'd2;
   assign eoi_length = pos_ff + jfbs_pkg::OffsetBits'(1) - start_ff;

   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      length_in  = length_ff;
      prev_ff_in = prev_ff_ff;
      len_hi_in  = len_hi_ff;
      skip_in    = skip_ff;
      found_in   = found_ff;
      case (phase_ff)
         PH_SOI: begin
            if (prev_ff_ff && data_byte == jfbs_pkg::SoiCode) begin
               start_in   = pos_ff - jfbs_pkg::OffsetBits'(1);
               prev_ff_in = 1'b0;
               phase_in   = PH_APPMARK;
            end else begin
               prev_ff_in = is_ff;
            end
         end
         PH_APPMARK: begin
            if (is_ff) begin
               phase_in = PH_APPTYPE;
            end else begin
               prev_ff_in = 1'b0;
               phase_in   = PH_EOI;
            end
         end
         PH_APPTYPE: begin
            if ((data_byte & jfbs_pkg::AppMask) == jfbs_pkg::AppCode) begin
               phase_in = PH_LENHI;
            end else if (is_eoi) begin
               // marker prefix already seen, this byte may close the frame
               found_in   = 1'b1;
               length_in  = eoi_length;
               prev_ff_in = 1'b0;
               phase_in   = PH_DONE;
            end else begin
               prev_ff_in = is_ff;
               phase_in   = PH_EOI;
            end
         end
         PH_LENHI: begin
            len_hi_in = data_byte;
            phase_in  = PH_LENLO;
         end
         PH_LENLO: begin
            skip_in  = seg_skip;
            phase_in = (seg_skip == 16'd0) ? PH_APPMARK : PH_SKIP;
         end
         PH_SKIP: begin
            skip_in = (skip_ff != 16'd0) ? skip_ff - 16'd1 : skip_ff;
            if (skip_ff <= 16'd1) begin
               phase_in = PH_APPMARK;
            end
         end
         PH_EOI: begin
            if (prev_ff_ff && is_eoi) begin
               found_in   = 1'b1;
               length_in  = eoi_length;
               prev_ff_in = 1'b0;
               phase_in   = PH_DONE;
            end else begin
               prev_ff_in = is_ff;
            end
         end
         default: begin
         end
      endcase
      pos_in = pos_ff + jfbs_pkg::OffsetBits'(1);
   end

   // result seen on the last word, taken from the updated state
   always_comb begin
      result.found  = found_in;
      result.start  = found_in ? jfbs_pkg::ResultBits'(start_in)  : '0;
      result.length = found_in ? jfbs_pkg::ResultBits'(length_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && last_byte)) begin
         phase_ff   <= PH_SOI;
         pos_ff     <= '0;
         start_ff   <= '0;
         length_ff  <= '0;
         prev_ff_ff <= 1'b0;
         len_hi_ff  <= '0;
         skip_ff    <= '0;
         found_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         start_ff   <= start_in;
         length_ff  <= length_in;
         prev_ff_ff <= prev_ff_in;
         len_hi_ff  <= len_hi_in;
         skip_ff    <= skip_in;
         found_ff   <= found_in;
      end
   end

endmodule

// ===== hdl/jpeg_frame_boundary_scanner_core.sv =====
// jpeg_frame_boundary_scanner_core: finds one jpeg frame (start to end marker) in a byte stream
// depends on jfbs_pkg and jfbs_scan
// an accepted byte flagged last passes the input register, then the result register, before its word shows on rsp
// throughput: one byte per cycle while no last byte is stalled; input register, scan state update, result register
// a finished result waiting on rsp_tready stalls only the next last byte
// reset: synchronous, active high; clears all scan state and both valid flags
module jpeg_frame_boundary_scanner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] start_offset, [63:32] frame_length
   output logic        rsp_tuser    // frame_found
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   logic                      out_valid_ff;
   jfbs_pkg::scan_result_type out_ff;

   jfbs_pkg::scan_result_type result;
   logic stall;
   logic step_en;

   // only a last word needs room in the result register
   assign stall      = in_valid_ff && in_last_ff && out_valid_ff && !rsp_tready;
   assign step_en    = in_valid_ff && !stall;
   assign req_tready = !in_valid_ff || !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (step_en) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   jfbs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.length, out_ff.start};
   assign rsp_tuser  = out_ff.found;

endmodule

// ===== verif/jpeg_frame_boundary_scanner_core_test.sv =====
// jpeg_frame_boundary_scanner_core_test: self-checking bench for the jpeg frame scanner
// drives byte streams on req, predicts frame start and length, checks every rsp word
// depends on jfbs_pkg and jpeg_frame_boundary_scanner_core
`timescale 1ns / 100ps

module jpeg_frame_boundary_scanner_core_test;

   localparam int RandomBytes = 1400;
   localparam int StallLimit  = 2000;
   localparam int HoldCycles  = 400;
   localparam int IdlePct     = 28;

   typedef enum logic [2:0] {
      SEEK_SOI, APP_MARK, APP_TYPE, LEN_HI, LEN_LO, SKIP_BODY, SEEK_EOI, FRAME_DONE
   } scan_phase_type;

   typedef struct {
      logic [7:0]                data;
      logic                      last;
      bit                        typed;
      jfbs_pkg::scan_result_type res;
   } byte_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [31:0] start_offset, [63:32] frame_length
   logic        rsp_tuser;   // frame_found

   jfbs_pkg::scan_result_type expected_frames[$];
   logic [7:0]                stream_bytes[$];
   int                        mismatch_count = 0;
   int                        stall_cycles   = 0;
   bit                        no_idle        = 1'b0;
   bit                        hold_request   = 1'b0;

   // scanner state as seen by the predictor
   scan_phase_type       phase;
   jfbs_pkg::offset_type pos_q;
   jfbs_pkg::offset_type soi_at;
   jfbs_pkg::offset_type frame_len;
   logic                 ff_seen;
   logic [7:0]           len_hi;
   logic [16:0]          skip_left;
   logic                 eoi_seen;

   // directed streams: minimal frame, single byte, short app length with trailing
   // byte, junk before start marker, stream cut inside the app header
   byte_row_type directed_rows [25] = '{
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hD8, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hD9, 1'b1, 1'b1, '{1'b1, 32'd0, 32'd4}},
      '{8'h00, 1'b1, 1'b1, '{1'b0, 32'd0, 32'd0}},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hD8, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hE1, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hD9, 1'b0, 1'b0, '0},
      '{8'h55, 1'b1, 1'b1, '{1'b1, 32'd0, 32'd8}},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hD8, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hD9, 1'b0, 1'b0, '0}, '{8'hFF, 1'b1, 1'b1, '{1'b1, 32'd1, 32'd4}},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hD8, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0}, '{8'hE0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{1'b0, 32'd0, 32'd0}}
   };

   jpeg_frame_boundary_scanner_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_scan();
      phase     = SEEK_SOI;
      pos_q     = '0;
      soi_at    = '0;
      frame_len = '0;
      ff_seen   = 1'b0;
      len_hi    = '0;
      skip_left = '0;
      eoi_seen  = 1'b0;
   endfunction

   function automatic void check_eoi(input logic [7:0] b, input jfbs_pkg::offset_type pos);
      if (ff_seen && b == jfbs_pkg::EoiCode) begin
         eoi_seen  = 1'b1;
         frame_len = pos + jfbs_pkg::OffsetBits'(1) - soi_at;
         ff_seen   = 1'b0;
         phase     = FRAME_DONE;
      end else begin
         ff_seen = (b == jfbs_pkg::MarkerPrefix);
         phase   = SEEK_EOI;
      end
   endfunction

   // advances the scan by one byte; returns 1 when the byte closes a stream
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output jfbs_pkg::scan_result_type res);
      jfbs_pkg::offset_type pos;
      logic [15:0]          seg_len;
      pos = pos_q;
      res = '0;
      case (phase)
         SEEK_SOI: begin
            if (ff_seen && b == jfbs_pkg::SoiCode) begin
               soi_at  = pos - jfbs_pkg::OffsetBits'(1);
               ff_seen = 1'b0;
               phase   = APP_MARK;
            end else begin
               ff_seen = (b == jfbs_pkg::MarkerPrefix);
            end
         end
         APP_MARK: begin
            if (b == jfbs_pkg::MarkerPrefix) begin
               phase = APP_TYPE;
            end else begin
               ff_seen = 1'b0;
               phase   = SEEK_EOI;
            end
         end
         APP_TYPE: begin
            if ((b & jfbs_pkg::AppMask) == jfbs_pkg::AppCode) begin
               phase = LEN_HI;
            end else begin
               ff_seen = 1'b1;
               check_eoi(b, pos);
            end
         end
         LEN_HI: begin
            len_hi = b;
            phase  = LEN_LO;
         end
         LEN_LO: begin
            seg_len = {len_hi, b};
            // a length below 2 never rewinds the scan
            if (seg_len < 16'd2) seg_len = 16'd2;
            skip_left = 17'(seg_len) - 17'd2;
            phase     = (skip_left == 17'd0) ? APP_MARK : SKIP_BODY;
         end
         SKIP_BODY: begin
            if (skip_left != 17'd0) skip_left = skip_left - 17'd1;
            if (skip_left == 17'd0) phase = APP_MARK;
         end
         SEEK_EOI: check_eoi(b, pos);
         default: ;
      endcase
      pos_q = pos + jfbs_pkg::OffsetBits'(1);
      if (!last) return 1'b0;
      if (eoi_seen) begin
         res.found  = 1'b1;
         res.start  = soi_at[jfbs_pkg::ResultBits-1:0];
         res.length = frame_len[jfbs_pkg::ResultBits-1:0];
      end
      clear_scan();
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return jfbs_pkg::MarkerPrefix;
         1: return jfbs_pkg::SoiCode;
         2: return jfbs_pkg::EoiCode;
         3: return jfbs_pkg::AppCode | 8'($urandom_range(15));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic void append_byte(input logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endfunction

   // mostly well-formed frames with random content; the rest is noise
   task automatic build_stream();
      int          n_app;
      int          cut;
      logic [15:0] seg_len;
      stream_bytes.delete();
      if ($urandom_range(99) < 70) begin
         repeat ($urandom_range(4)) append_byte(pick_byte());
         append_byte(jfbs_pkg::MarkerPrefix);
         append_byte(jfbs_pkg::SoiCode);
         n_app = $urandom_range(3);
         repeat (n_app) begin
            append_byte(jfbs_pkg::MarkerPrefix);
            append_byte(jfbs_pkg::AppCode | 8'($urandom_range(15)));
            case ($urandom_range(49))
               0, 1, 2, 3, 4: seg_len = 16'($urandom_range(1));
               5:             seg_len = 16'($urandom_range(400, 200));
               default:       seg_len = 16'($urandom_range(10, 2));
            endcase
            append_byte(seg_len[15:8]);
            append_byte(seg_len[7:0]);
            if (seg_len > 2) repeat (seg_len - 2) append_byte(pick_byte());
         end
         repeat ($urandom_range(8)) append_byte(pick_byte());
         if ($urandom_range(99) < 85) begin
            append_byte(jfbs_pkg::MarkerPrefix);
            append_byte(jfbs_pkg::EoiCode);
         end
         repeat ($urandom_range(3)) append_byte(pick_byte());
         // truncated streams stop before their last byte, anywhere past the first
         if ($urandom_range(99) < 15 && stream_bytes.size() > 1) begin
            cut = $urandom_range(stream_bytes.size() - 1, 1);
            stream_bytes = stream_bytes[0:cut-1];
         end
      end else begin
         repeat ($urandom_range(12, 1)) append_byte(pick_byte());
      end
   endtask

   task automatic send_word(input logic [7:0] d, input logic l, input bit typed,
                            input jfbs_pkg::scan_result_type typed_res);
      jfbs_pkg::scan_result_type pred;
      while (!no_idle && $urandom_range(99) < IdlePct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      if (scan_byte(d, l, pred))
         expected_frames.insert(expected_frames.size(), typed ? typed_res : pred);
   endtask

   initial begin
      int sent;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      clear_scan();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].res);

      sent = 0;
      while (sent < RandomBytes) begin
         build_stream();
         foreach (stream_bytes[i]) begin
            if (sent == 200) hold_request = 1'b1;
            no_idle = (sent >= 600 && sent < 850);
            send_word(stream_bytes[i], i == stream_bytes.size() - 1, 1'b0, '0);
            sent++;
         end
      end
      no_idle = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // result side: random back pressure plus one long hold-off
   initial begin
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(99) >= IdlePct);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      jfbs_pkg::scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $error("unexpected result word: tuser %0d tdata %h", rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("frame_found expected %0d actual %0d", want.found, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[31:0] !== want.start) begin
               $error("start_offset expected %0d actual %0d", want.start, rsp_tdata[31:0]);
               mismatch_count++;
            end
            if (rsp_tdata[63:32] !== want.length) begin
               $error("frame_length expected %0d actual %0d", want.length,
                      rsp_tdata[63:32]);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
hdl/jfbs_pkg.sv
hdl/jfbs_scan.sv
hdl/jpeg_frame_boundary_scanner_core.sv
verif/jpeg_frame_boundary_scanner_core_test.sv
